FILE: design/mpq_pkg.sv
// Shared types and constants for the max priority queue.
package mpq_pkg;

  // Number of cells in the sorted chain.
  localparam int unsigned CAPACITY = 16;
  // Width of the internal occupancy counter.
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  // Width of the reported entry count field.
  localparam int unsigned COUNT_OUT_W = 5;

  // Operation codes of an input item.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED     = 2'd0,
    ST_REMOVED      = 2'd1,
    ST_REMOVE_EMPTY = 2'd2,
    ST_INSERT_FULL  = 2'd3
  } status_e;

  // One stored entry.
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

FILE: design/max_priority_queue_unit.sv
// Top level of the max priority queue: sorted cell chain, counter and result register.
//
// The queue keeps up to CAPACITY entries in a chain of cells sorted by priority, highest
// first, newest first among equal priorities. An insert is placed by every cell comparing
// its entry against the new one; a remove shifts the whole chain one cell toward the head.
// The result of each accepted item appears in the output register on the next cycle, and a
// new item is taken in every cycle in which the output register is empty or being drained.
// The output register is the only limit on throughput: with the result side always ready
// the block sustains one item per cycle.
module max_priority_queue_unit
  import mpq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // value [31:0], priority_req [47:32]
  input  logic        s_axis_tuser,   // op [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // removed_value [31:0], now_empty [32],
                                      // entry_count [37:33], zero [39:38]
  output logic [1:0]  m_axis_tuser    // status [1:0]
);

  logic       in_accept;
  op_e        op;
  entry_t     new_entry;
  cell_ctrl_t ctrl;

  logic [CNT_W-1:0] count_q, count_d;
  logic             is_full, is_empty;

  entry_t               cell_entry [CAPACITY];
  logic [CAPACITY-1:0]  cell_valid;
  logic [CAPACITY-1:0]  cell_beats;

  logic               out_valid_q;
  logic signed [31:0] out_value_q, out_value_d;
  status_e            out_status_q, out_status_d;
  logic [CNT_W-1:0]   out_count_q;
  logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

  // Input decode and handshake.
  assign s_axis_tready   = !out_valid_q || m_axis_tready;
  assign in_accept       = s_axis_tvalid && s_axis_tready;
  assign op              = op_e'(s_axis_tuser);
  assign new_entry.value = s_axis_tdata[31:0];
  assign new_entry.prio  = s_axis_tdata[47:32];

  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);

  // Command to the chain and the result of this item.
  always_comb begin
    ctrl         = '0;
    count_d      = count_q;
    out_value_d  = '0;
    out_status_d = ST_INSERTED;
    case (op)
      OP_INSERT: begin
        if (is_full) begin
          out_status_d = ST_INSERT_FULL;
        end else begin
          ctrl.ins     = in_accept;
          count_d      = count_q + 1'b1;
          out_status_d = ST_INSERTED;
        end
      end
      OP_REMOVE: begin
        if (is_empty) begin
          out_status_d = ST_REMOVE_EMPTY;
        end else begin
          ctrl.rem     = in_accept;
          count_d      = count_q - 1'b1;
          out_value_d  = cell_entry[0].value;
          out_status_d = ST_REMOVED;
        end
      end
      default: begin
        out_status_d = ST_INSERTED;
      end
    endcase
  end

  // Chain of cells, head at index zero.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_valid, right_valid, left_beats;

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_valid = 1'b0;
      assign left_beats = 1'b1;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_beats = cell_beats[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = new_entry;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
      assign right_valid = cell_valid[i+1];
    end

    mpq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_entry_i   (new_entry),
      .left_beats_i  (left_beats),
      .left_entry_i  (left_entry),
      .left_valid_i  (left_valid),
      .right_entry_i (right_entry),
      .right_valid_i (right_valid),
      .entry_o       (cell_entry[i]),
      .valid_o       (cell_valid[i]),
      .beats_o       (cell_beats[i])
    );
  end

  // Occupancy counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        count_q <= count_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_count_q  <= count_d;
    end
  end

  // Output packing.
  assign count_ext     = {{COUNT_OUT_W{1'b0}}, out_count_q};
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, count_ext[COUNT_OUT_W-1:0], (out_count_q == '0), out_value_q};
  assign m_axis_tuser  = out_status_q;

  // The occupancy never goes past the number of cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_W'(CAPACITY))
    else $error("occupancy exceeds capacity");

  // The head cell holds an entry exactly when the queue is not empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cell_valid[0] == !is_empty)
    else $error("head cell valid disagrees with occupancy");

  // The number of valid cells always equals the occupancy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("valid cells disagree with occupancy");

  // A successful remove lowers the occupancy by one on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && op == OP_REMOVE && !is_empty) |=> count_q == $past(count_q) - 1'b1)
    else $error("remove did not lower occupancy");

endmodule

FILE: design/mpq_cell.sv
// One cell of the sorted chain: holds a single entry and its valid bit.
module mpq_cell
  import mpq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_entry_i,
  input  logic       left_beats_i,
  input  entry_t     left_entry_i,
  input  logic       left_valid_i,
  input  entry_t     right_entry_i,
  input  logic       right_valid_i,
  output entry_t     entry_o,
  output logic       valid_o,
  output logic       beats_o
);

  entry_t entry_q, entry_d;
  logic   valid_q, valid_d;

  // The held entry stays ahead of a new one only with a strictly greater priority,
  // so that among equal priorities the newest entry sits closest to the head.
  assign beats_o = valid_q && (entry_q.prio > new_entry_i.prio);

  // Insert keeps, takes the new entry, or shifts from the left; remove shifts from the right.
  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.ins) begin
      if (beats_o) begin
        entry_d = entry_q;
        valid_d = valid_q;
      end else if (left_beats_i) begin
        entry_d = new_entry_i;
        valid_d = 1'b1;
      end else begin
        entry_d = left_entry_i;
        valid_d = left_valid_i;
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_entry_i;
      valid_d = right_valid_i;
    end
  end

  // Valid bit is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry payload needs no reset.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;

endmodule
